// File: hw/rtl/aiur_pkg.sv
// aiur_pkg: types, codes and helpers shared by the responder modules
// no dependencies

package aiur_pkg;

  localparam int MASK_W        = 8;
  localparam int SHARD_IDX_W   = 3;
  localparam int SHARD_BITS_DEF = 8;
  localparam int CFG_DATA_W    = 48;
  localparam int CFG_IDX_W     = 2;

  localparam logic [CFG_IDX_W-1:0] REG_OWN_IP       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OWN_MAC      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SERVICE_PORT = 2'd2;

  localparam logic [31:0] OWN_IP_RST       = 32'hC0A8_0460;
  localparam logic [47:0] OWN_MAC_RST      = 48'h0;
  localparam logic [15:0] SERVICE_PORT_RST = 16'd12345;

  localparam logic [1:0] ACT_DROP  = 2'd0;
  localparam logic [1:0] ACT_ARP   = 2'd1;
  localparam logic [1:0] ACT_ECHO  = 2'd2;
  localparam logic [1:0] ACT_SHARD = 2'd3;

  localparam logic [15:0] ETH_ARP       = 16'h0806;
  localparam logic [15:0] ETH_IPV4      = 16'h0800;
  localparam logic [7:0]  PROTO_ICMP    = 8'd1;
  localparam logic [7:0]  PROTO_UDP     = 8'd17;
  localparam logic [15:0] ARP_REQUEST   = 16'd1;
  localparam logic [15:0] ARP_REPLY     = 16'd2;
  localparam logic [15:0] ICMP_ECHO_REQ = 16'd8;
  localparam logic [15:0] ICMP_ECHO_REP = 16'd0;
  // ones-complement of the request type word, 0xffff with 0x0800 removed
  localparam logic [15:0] CK_REQ_NEG    = 16'hF7FF;
  localparam logic [15:0] CK_REP_WORD   = 16'h0000;

  typedef struct packed {
    logic [15:0] eth_type;
    logic [7:0]  next_proto;
    logic [47:0] eth_src;
    logic [47:0] eth_dst;
    logic [47:0] sender_hw;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] op_code;
    logic [15:0] echo_csum;
    logic [15:0] udp_sport;
    logic [15:0] udp_dport;
    logic [7:0]  copy_mask;
  } in_item_t;

  typedef struct packed {
    logic [1:0]             action;
    logic [47:0]            out_eth_src;
    logic [47:0]            out_eth_dst;
    logic [47:0]            out_target_hw;
    logic [31:0]            out_src_ip;
    logic [31:0]            out_dst_ip;
    logic [15:0]            out_op_code;
    logic [15:0]            out_cksum;
    logic [15:0]            out_src_port;
    logic [15:0]            out_dst_port;
    logic [SHARD_IDX_W-1:0] shard_index;
    logic                   last;
  } out_item_t;

  typedef struct packed {
    out_item_t         res;
    logic [MASK_W-1:0] rem;
  } fan_item_t;

  function automatic logic [SHARD_IDX_W-1:0] lowest_bit(input logic [MASK_W-1:0] m);
    logic [SHARD_IDX_W-1:0] idx;
    idx = '0;
    for (int i = MASK_W - 1; i >= 0; i--) begin
      if (m[i]) idx = SHARD_IDX_W'(i);
    end
    return idx;
  endfunction

endpackage

// File: hw/rtl/aiur_if.sv
// aiur_if: valid/ready channel interfaces for frame headers and replies
// depends on aiur_pkg

interface aiur_in_if import aiur_pkg::*;;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface aiur_out_if import aiur_pkg::*;;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// File: hw/rtl/aiur_fanout.sv
// aiur_fanout: output register that expands shard copies, one per ready cycle
// depends on aiur_pkg, aiur_if

module aiur_fanout import aiur_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  fan_item_t        in_data,
  aiur_out_if.source       out
);

  logic              out_valid;
  out_item_t         out_data;
  logic [MASK_W-1:0] rem;
  logic [MASK_W-1:0] rem_next;
  logic              advance;
  logic              more;

  assign advance  = !out_valid || out.ready;
  assign more     = (rem != '0);
  assign in_ready = advance && !more;
  assign rem_next = rem & (rem - MASK_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      rem       <= '0;
    end else if (advance) begin
      if (more) begin
        out_valid <= 1'b1;
        rem       <= rem_next;
      end else if (in_valid) begin
        out_valid <= 1'b1;
        rem       <= in_data.rem;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (more) begin
        out_data.shard_index <= lowest_bit(rem);
        out_data.last        <= (rem_next == '0);
      end else if (in_valid) begin
        out_data <= in_data.res;
      end
    end
  end

  assign out.valid = out_valid;
  assign out.data  = out_data;

endmodule

// File: hw/rtl/arp_icmp_udp_responder.sv
// arp_icmp_udp_responder: ARP reply, ICMP echo reply and UDP shard fanout
// an accepted item passes stage 1, stage 2 and the output register to reply
// throughput: one item per cycle if reply is ready; a UDP item with n shard
// copies holds the output register, one copy per cycle, and stalls the input
// reset: clears all valid bits and loads default own_ip, own_mac, service_port

module arp_icmp_udp_responder import aiur_pkg::*; #(
  parameter int SHARD_BITS = SHARD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  aiur_in_if.sink               frame,
  aiur_out_if.source            reply
);

  localparam int USE_BITS = (SHARD_BITS < MASK_W) ? SHARD_BITS : MASK_W;
  localparam logic [MASK_W-1:0] USE_MASK = MASK_W'((1 << USE_BITS) - 1);

  logic [31:0] own_ip;
  logic [47:0] own_mac;
  logic [15:0] service_port;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_ip       <= OWN_IP_RST;
      own_mac      <= OWN_MAC_RST;
      service_port <= SERVICE_PORT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OWN_IP:       own_ip       <= cfg_data[31:0];
        REG_OWN_MAC:      own_mac      <= cfg_data[47:0];
        REG_SERVICE_PORT: service_port <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // stage 1: classify
  logic     s1_valid;
  logic     s1_ready;
  in_item_t s1_data;
  logic     s1_arp_hit;
  logic     s1_echo_hit;
  logic     s1_udp_hit;

  // stage 2: build first result
  logic      s2_valid;
  logic      s2_ready;
  fan_item_t s2_data;

  logic fan_ready;

  assign s1_ready    = !s1_valid || s2_ready;
  assign s2_ready    = !s2_valid || fan_ready;
  assign frame.ready = s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= frame.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_data     <= frame.data;
      s1_arp_hit  <= (frame.data.eth_type == ETH_ARP) &&
                     (frame.data.dst_ip == own_ip) &&
                     (frame.data.op_code == ARP_REQUEST);
      s1_echo_hit <= (frame.data.eth_type == ETH_IPV4) &&
                     (frame.data.next_proto == PROTO_ICMP) &&
                     (frame.data.op_code == ICMP_ECHO_REQ) &&
                     (frame.data.dst_ip == own_ip);
      s1_udp_hit  <= (frame.data.eth_type == ETH_IPV4) &&
                     (frame.data.next_proto == PROTO_UDP) &&
                     (frame.data.udp_dport == service_port);
    end
  end

  logic [16:0]       ck_sum;
  logic [16:0]       ck_fold1;
  logic [16:0]       ck_fold2;
  logic [MASK_W-1:0] used;
  logic [MASK_W-1:0] used_rest;
  fan_item_t         s2_next;

  always_comb begin
    ck_sum    = {1'b0, ~s1_data.echo_csum} + {1'b0, CK_REQ_NEG} + {1'b0, CK_REP_WORD};
    ck_fold1  = {1'b0, ck_sum[15:0]} + 17'(ck_sum[16]);
    ck_fold2  = {1'b0, ck_fold1[15:0]} + 17'(ck_fold1[16]);
    used      = s1_data.copy_mask & USE_MASK;
    used_rest = used & (used - MASK_W'(1));

    s2_next          = '0;
    s2_next.res.last = 1'b1;
    priority if (s1_arp_hit) begin
      s2_next.res.action        = ACT_ARP;
      s2_next.res.out_eth_src   = own_mac;
      s2_next.res.out_eth_dst   = s1_data.eth_src;
      s2_next.res.out_target_hw = s1_data.sender_hw;
      s2_next.res.out_src_ip    = own_ip;
      s2_next.res.out_dst_ip    = s1_data.src_ip;
      s2_next.res.out_op_code   = ARP_REPLY;
    end else if (s1_echo_hit) begin
      s2_next.res.action      = ACT_ECHO;
      s2_next.res.out_eth_src = s1_data.eth_dst;
      s2_next.res.out_eth_dst = s1_data.eth_src;
      s2_next.res.out_src_ip  = s1_data.dst_ip;
      s2_next.res.out_dst_ip  = s1_data.src_ip;
      s2_next.res.out_op_code = ICMP_ECHO_REP;
      s2_next.res.out_cksum   = ~ck_fold2[15:0];
    end else if (s1_udp_hit) begin
      s2_next.res.action       = ACT_SHARD;
      s2_next.res.out_eth_src  = s1_data.eth_dst;
      s2_next.res.out_eth_dst  = s1_data.eth_src;
      s2_next.res.out_src_ip   = s1_data.dst_ip;
      s2_next.res.out_dst_ip   = s1_data.src_ip;
      s2_next.res.out_src_port = s1_data.udp_dport;
      s2_next.res.out_dst_port = s1_data.udp_sport;
      s2_next.res.shard_index  = lowest_bit(used);
      s2_next.res.last         = (used_rest == '0);
      s2_next.rem              = used_rest;
    end else begin
      s2_next.res.action = ACT_DROP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready) begin
      s2_data <= s2_next;
    end
  end

  // stage 3: output register and shard expansion
  aiur_fanout u_fanout (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s2_valid),
    .in_ready (fan_ready),
    .in_data  (s2_data),
    .out      (reply)
  );

  // a delivered copy that is not last is followed by another copy
  a_fanout_continues: assert property (@(posedge clk) disable iff (rst)
    reply.valid && reply.ready && !reply.data.last |=>
      reply.valid && reply.data.action == ACT_SHARD)
    else $error("shard fanout stopped before last copy");

  // only shard copies may be non-last
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    reply.valid && reply.data.action != ACT_SHARD |-> reply.data.last)
    else $error("non-shard result without last");

  // no new item enters stage 2 while its result is stuck
  a_s2_hold: assert property (@(posedge clk) disable iff (rst)
    s2_valid && !fan_ready |=> s2_valid && $stable(s2_data))
    else $error("stage 2 item lost under stall");

  // input is held off while copies remain
  a_no_accept_mid_fanout: assert property (@(posedge clk) disable iff (rst)
    reply.valid && !reply.data.last |-> !fan_ready)
    else $error("fanout accepted item mid expansion");

endmodule
